FILE: rtl/kap_pkg.sv
// ----------------------------------------------------------------------------
// kap_pkg
// Shared types and constants for the key auto-repeat poller.
// ----------------------------------------------------------------------------
package kap_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CntW  = 8;
  localparam int unsigned CfgIdxW = 2;

  // register reset values
  localparam logic             ActiveLevelRst  = 1'b0;
  localparam logic [TimeW-1:0] PollIntervalRst = 32'd10000;
  localparam logic [TimeW-1:0] RepeatStartRst  = 32'd500000;
  localparam logic [TimeW-1:0] RepeatWorkRst   = 32'd100000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVE_LEVEL  = 2'd0,
    CFG_POLL_INTERVAL = 2'd1,
    CFG_REPEAT_START  = 2'd2,
    CFG_REPEAT_WORK   = 2'd3
  } kap_cfg_idx_t;

  typedef enum logic [2:0] {
    EV_NOKEY  = 3'd0,
    EV_FRONT  = 3'd1,
    EV_REPEAT = 3'd2,
    EV_HELD   = 3'd3,
    EV_REAR   = 3'd4
  } kap_event_t;

  typedef struct packed {
    logic             pin_level;
    logic [TimeW-1:0] now_us;
  } kap_in_t;

  typedef struct packed {
    kap_event_t       key_event;
    logic             key_down;
    logic [CntW-1:0]  repeat_total;
  } kap_out_t;

  typedef struct packed {
    logic             active_level;
    logic [TimeW-1:0] poll_interval_us;
    logic [TimeW-1:0] repeat_start_us;
    logic [TimeW-1:0] repeat_work_us;
  } kap_cfg_t;

endpackage

FILE: rtl/key_autorepeat_poller.sv
// ----------------------------------------------------------------------------
// key_autorepeat_poller
// Typematic key evaluator with poll gating and auto-repeat timing.
// ----------------------------------------------------------------------------
// Takes one pin sample with its microsecond timestamp per clock, unless held by
// back-pressure, and returns exactly one result per sample. A sample sits in an
// input register, is evaluated by one subtract-and-compare stage against the
// repeat state, and its result lands in an output register. Sustained rate is
// one item per cycle while out_ready stays high; the single evaluation stage
// that updates the repeat state sets that figure. Configuration must be written
// only while the block is idle; the block itself does not enforce this.
module key_autorepeat_poller (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  kap_pkg::kap_in_t            in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output kap_pkg::kap_out_t           out_item,
  input  logic                        cfg_we,
  input  logic [kap_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [kap_pkg::TimeW-1:0]   cfg_wdata
);
  import kap_pkg::*;

  kap_cfg_t cfg;
  kap_out_t result;

  logic     s1_valid_r, s1_valid_nxt;
  kap_in_t  s1_item_r;
  logic     out_valid_r, out_valid_nxt;
  kap_out_t out_item_r;

  logic     out_free;
  logic     s1_adv;
  logic     in_fire;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ready);

  kap_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  kap_eval u_eval (
    .clk    (clk),
    .rst_n  (rst_n),
    .advance(s1_adv),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: rtl/kap_cfg_regs.sv
// ----------------------------------------------------------------------------
// kap_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module kap_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [kap_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [kap_pkg::TimeW-1:0]   cfg_wdata,
  output kap_pkg::kap_cfg_t           cfg
);
  import kap_pkg::*;

  kap_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (kap_cfg_idx_t'(cfg_index))
        CFG_ACTIVE_LEVEL:  cfg_nxt.active_level     = cfg_wdata[0];
        CFG_POLL_INTERVAL: cfg_nxt.poll_interval_us = cfg_wdata;
        CFG_REPEAT_START:  cfg_nxt.repeat_start_us  = cfg_wdata;
        CFG_REPEAT_WORK:   cfg_nxt.repeat_work_us   = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_level     <= ActiveLevelRst;
      cfg_r.poll_interval_us <= PollIntervalRst;
      cfg_r.repeat_start_us  <= RepeatStartRst;
      cfg_r.repeat_work_us   <= RepeatWorkRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/kap_eval.sv
// ----------------------------------------------------------------------------
// kap_eval
// Poll gating, key classification and repeat timing state.
// ----------------------------------------------------------------------------
module kap_eval (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  kap_pkg::kap_in_t  item,
  input  kap_pkg::kap_cfg_t cfg,
  output kap_pkg::kap_out_t result
);
  import kap_pkg::*;

  logic [TimeW-1:0] last_poll_r, last_poll_nxt;
  logic [TimeW-1:0] slot_time_r, slot_time_nxt;
  logic [TimeW-1:0] delay_r, delay_nxt;
  logic             armed_r, armed_nxt;
  logic             pressed_r, pressed_nxt;
  logic [CntW-1:0]  count_r, count_nxt;

  logic [TimeW-1:0] poll_elapsed;
  logic [TimeW-1:0] hold_elapsed;
  logic             poll_early;
  logic             key_on;
  kap_event_t       ev;

  // wrapping differences
  assign poll_elapsed = item.now_us - last_poll_r;
  assign hold_elapsed = item.now_us - slot_time_r;
  assign poll_early   = poll_elapsed < cfg.poll_interval_us;
  assign key_on       = item.pin_level == cfg.active_level;

  always_comb begin
    last_poll_nxt = last_poll_r;
    slot_time_nxt = slot_time_r;
    delay_nxt     = delay_r;
    armed_nxt     = armed_r;
    pressed_nxt   = pressed_r;
    count_nxt     = count_r;
    ev            = EV_NOKEY;
    if (!poll_early) begin
      last_poll_nxt = item.now_us;
      if (!key_on) begin
        pressed_nxt = 1'b0;
        if (armed_r) begin
          armed_nxt = 1'b0;
          ev        = EV_REAR;
        end
      end else begin
        pressed_nxt = 1'b1;
        if (!armed_r) begin
          slot_time_nxt = item.now_us;
          delay_nxt     = cfg.repeat_start_us;
          armed_nxt     = 1'b1;
          count_nxt     = '0;
          ev            = EV_FRONT;
        end else if (hold_elapsed > delay_r) begin
          slot_time_nxt = item.now_us;
          delay_nxt     = cfg.repeat_work_us;
          count_nxt     = count_r + CntW'(1);
          ev            = EV_REPEAT;
        end else begin
          ev = EV_HELD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_poll_r <= '0;
      slot_time_r <= '0;
      delay_r     <= '0;
      armed_r     <= 1'b0;
      pressed_r   <= 1'b0;
      count_r     <= '0;
    end else if (advance) begin
      last_poll_r <= last_poll_nxt;
      slot_time_r <= slot_time_nxt;
      delay_r     <= delay_nxt;
      armed_r     <= armed_nxt;
      pressed_r   <= pressed_nxt;
      count_r     <= count_nxt;
    end
  end

  assign result.key_event    = ev;
  assign result.key_down     = pressed_nxt;
  assign result.repeat_total = count_nxt;

endmodule

FILE: bench/key_event_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_event_checker
// Watches the sample and event channels of the key auto-repeat poller, keeps
// its own copy of the poll and repeat timing state, and compares every event
// item with the oldest predicted one. Register writes are tracked from the
// write port.
// ----------------------------------------------------------------------------
module key_event_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  kap_pkg::kap_in_t             in_item,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  kap_pkg::kap_out_t            out_item,
  input  logic                         cfg_we,
  input  logic [kap_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [kap_pkg::TimeW-1:0]    cfg_wdata,
  output int unsigned                  mismatches,
  output int unsigned                  outstanding
);
  import kap_pkg::*;

  // register shadows
  logic             lvl_active;
  logic [TimeW-1:0] poll_gap;
  logic [TimeW-1:0] first_delay;
  logic [TimeW-1:0] next_delay;

  // timing state
  logic [TimeW-1:0] poll_stamp;
  logic [TimeW-1:0] slot_stamp;
  logic [TimeW-1:0] slot_delay;
  logic             armed;
  logic             held;
  logic [CntW-1:0]  rep_count;

  kap_out_t    expected_events[$];
  int unsigned fail_count;

  function automatic kap_out_t classify_sample(input kap_in_t s);
    kap_out_t   r;
    kap_event_t ev;
    ev = EV_NOKEY;
    // elapsed times are wrapping 32-bit differences
    if (s.now_us - poll_stamp >= poll_gap) begin
      poll_stamp = s.now_us;
      if (s.pin_level != lvl_active) begin
        held = 1'b0;
        if (armed) begin
          armed = 1'b0;
          ev = EV_REAR;
        end
      end else begin
        held = 1'b1;
        if (!armed) begin
          slot_stamp = s.now_us;
          slot_delay = first_delay;
          armed      = 1'b1;
          rep_count  = '0;
          ev = EV_FRONT;
        end else if (s.now_us - slot_stamp > slot_delay) begin
          slot_stamp = s.now_us;
          slot_delay = next_delay;
          rep_count  = rep_count + 1'b1;
          ev = EV_REPEAT;
        end else begin
          ev = EV_HELD;
        end
      end
    end
    r.key_event    = ev;
    r.key_down     = held;
    r.repeat_total = rep_count;
    return r;
  endfunction

  always @(posedge clk) begin
    kap_out_t want;
    if (!rst_n) begin
      lvl_active  = ActiveLevelRst;
      poll_gap    = PollIntervalRst;
      first_delay = RepeatStartRst;
      next_delay  = RepeatWorkRst;
      poll_stamp  = '0;
      slot_stamp  = '0;
      slot_delay  = '0;
      armed       = 1'b0;
      held        = 1'b0;
      rep_count   = '0;
      fail_count  = 0;
      expected_events.delete();
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ACTIVE_LEVEL:  lvl_active  = cfg_wdata[0];
          CFG_POLL_INTERVAL: poll_gap    = cfg_wdata;
          CFG_REPEAT_START:  first_delay = cfg_wdata;
          CFG_REPEAT_WORK:   next_delay  = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual event %0d down %0b total %0d",
                   $time, out_item.key_event, out_item.key_down, out_item.repeat_total);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          if (out_item.key_event !== want.key_event) begin
            $display("%0t: key_event expected %0d actual %0d",
                     $time, want.key_event, out_item.key_event);
            fail_count++;
          end
          if (out_item.key_down !== want.key_down) begin
            $display("%0t: key_down expected %0b actual %0b",
                     $time, want.key_down, out_item.key_down);
            fail_count++;
          end
          if (out_item.repeat_total !== want.repeat_total) begin
            $display("%0t: repeat_total expected %0d actual %0d",
                     $time, want.repeat_total, out_item.repeat_total);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) expected_events.push_back(classify_sample(in_item));
      mismatches  <= fail_count;
      outstanding <= expected_events.size();
    end
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives pin samples with timestamps into the key auto-repeat poller through
// a directed sequence and several randomized register settings, with random
// stalls on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
  import kap_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned Phases     = 8;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  kap_in_t             in_item;
  logic                out_valid;
  logic                out_ready = 1'b1;
  kap_out_t            out_item;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [TimeW-1:0]    cfg_wdata;
  int unsigned         mismatches;
  int unsigned         outstanding;
  logic                quiet;
  int unsigned         ready_run = 0;
  int unsigned         dead_cycles = 0;

  key_autorepeat_poller uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  key_event_checker events_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // event side back-pressure in bursts
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (ready_run == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        ready_run <= $urandom_range(1, 17);
      end else begin
        out_ready <= 1'b1;
        ready_run <= $urandom_range(1, 40);
      end
    end else begin
      ready_run <= ready_run - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      dead_cycles <= 0;
    end else if (dead_cycles == StallLimit) begin
      $display("key_autorepeat_poller verification failed");
      $finish;
    end else begin
      dead_cycles <= dead_cycles + 1;
    end
  end

  task automatic send_sample(input logic pin, input logic [TimeW-1:0] stamp);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{pin_level: pin, now_us: stamp};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic program_regs(input logic lvl, input logic [TimeW-1:0] poll,
                              input logic [TimeW-1:0] start, input logic [TimeW-1:0] work);
    logic [TimeW-1:0] word;
    // upper bits of the level write are don't-care
    word    = $urandom;
    word[0] = lvl;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ACTIVE_LEVEL;
    cfg_wdata <= word;
    @(posedge clk);
    cfg_index <= CFG_POLL_INTERVAL;
    cfg_wdata <= poll;
    @(posedge clk);
    cfg_index <= CFG_REPEAT_START;
    cfg_wdata <= start;
    @(posedge clk);
    cfg_index <= CFG_REPEAT_WORK;
    cfg_wdata <= work;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned phase, input int unsigned count);
    logic             lvl;
    logic [TimeW-1:0] poll;
    logic [TimeW-1:0] start;
    logic [TimeW-1:0] work;
    logic [TimeW-1:0] step_max;
    logic [TimeW-1:0] stamp;
    logic             pressed;
    int unsigned      run_left;
    settle();
    case (phase)
      0: begin
        // zero delays and long holds push the repeat count past its wrap
        lvl = 1'b1; poll = '0; start = '0; work = '0; step_max = 60;
      end
      1: begin
        lvl = 1'b0; poll = '1; start = '1; work = '1; step_max = '1;
      end
      2: begin
        lvl = 1'($urandom_range(0, 1)); poll = $urandom; start = $urandom; work = $urandom;
        step_max = '1;
      end
      default: begin
        lvl   = 1'($urandom_range(0, 1));
        poll  = $urandom_range(0, 40);
        start = $urandom_range(0, 400);
        work  = $urandom_range(0, 150);
        step_max = poll + 40;
      end
    endcase
    program_regs(lvl, poll, start, work);
    stamp    = $urandom;
    pressed  = 1'b0;
    run_left = 0;
    repeat (count) begin
      if (run_left == 0) begin
        pressed = !pressed;
        if (phase == 0) run_left = pressed ? $urandom_range(260, 340) : $urandom_range(1, 4);
        else run_left = $urandom_range(1, 30);
      end
      run_left--;
      if (phase != 0 && $urandom_range(0, 9) == 0) begin
        send_sample(1'($urandom_range(0, 1)), $urandom);
      end else begin
        if (step_max == '1) stamp = stamp + $urandom;
        else stamp = stamp + $urandom_range(0, step_max);
        send_sample(pressed ? lvl : !lvl, stamp);
      end
    end
  endtask

  initial begin
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_ACTIVE_LEVEL;
    cfg_wdata <= '0;
    quiet     <= 1'b0;
    rst_n     <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: early samples, exact poll boundary, repeat threshold
    send_sample(1'b0, 32'd0);
    send_sample(1'b0, 32'd9999);
    send_sample(1'b0, 32'd10000);
    send_sample(1'b1, 32'd15000);
    send_sample(1'b0, 32'd20000);
    send_sample(1'b0, 32'd510000);
    send_sample(1'b0, 32'd520000);
    send_sample(1'b0, 32'd620000);
    send_sample(1'b0, 32'd630000);
    send_sample(1'b1, 32'd640000);
    send_sample(1'b1, 32'd650000);
    // timestamp wrap
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_sample(1'b0, 32'd9998);
    send_sample(1'b0, 32'd9999);
    settle();

    // largest interval only passes one step short of a full wrap
    program_regs(1'b1, '1, '1, '1);
    send_sample(1'b1, 32'd9998);
    send_sample(1'b0, 32'd9997);
    send_sample(1'b1, 32'd0);
    settle();

    // zero interval and zero delays
    program_regs(1'b0, '0, '0, '0);
    send_sample(1'b0, 32'd100);
    send_sample(1'b0, 32'd100);
    send_sample(1'b0, 32'd101);
    send_sample(1'b0, 32'd101);
    send_sample(1'b1, 32'd101);
    send_sample(1'b1, 32'd101);

    for (int p = 0; p < Phases; p++) begin
      if (p == Phases - 1) quiet <= 1'b1;
      run_phase(p, (p == 0) ? 360 : 170);
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("key_autorepeat_poller verification clean");
    end else begin
      $display("key_autorepeat_poller verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/kap_pkg.sv
rtl/kap_cfg_regs.sv
rtl/kap_eval.sv
rtl/key_autorepeat_poller.sv
bench/key_event_checker.sv
bench/tb.sv
